// ----- hw/rtl/kfc_pkg.sv -----
package kfc_pkg;

    localparam int MAX_DISTINCT = 64;
    localparam int MAX_TEXT     = 512;
    localparam int MAX_GRAM     = 4;

    localparam int BYTE_W  = 8;
    localparam int GRAM_W  = MAX_GRAM * BYTE_W;
    localparam int COUNT_W = 10;
    localparam int LEN_W   = 3;
    localparam int TEXT_W  = $clog2(MAX_TEXT + 1);
    localparam int ADDR_W  = $clog2(MAX_DISTINCT);
    localparam int USED_W  = $clog2(MAX_DISTINCT + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic {
        KIND_FREQUENT  = 1'b0,
        KIND_NO_REPEAT = 1'b1
    } t_kind;

    typedef struct packed {
        logic [GRAM_W-1:0]  gram;
        logic [COUNT_W-1:0] count;
    } t_entry;

    // Clamps the programmed length into the supported range.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_GRAM)) begin
            n = LEN_W'(MAX_GRAM);
        end
        return n;
    endfunction

    function automatic logic [GRAM_W-1:0] gram_mask(input logic [LEN_W-1:0] n);
        logic [GRAM_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_GRAM; b++) begin
            if (LEN_W'(b) < n) begin
                m[b*BYTE_W +: BYTE_W] = {BYTE_W{1'b1}};
            end
        end
        return m;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

endpackage

// ----- hw/rtl/kfc_if.sv -----
interface kfc_in_if;
    logic                         valid;
    logic                         ready;
    logic [kfc_pkg::BYTE_W-1:0]   text_byte;
    logic                         is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface kfc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [kfc_pkg::GRAM_W-1:0]    gram;
    logic [kfc_pkg::COUNT_W-1:0]   occurrences;
    logic                          overflow;
    logic                          last_result;

    modport source (output valid, output kind, output gram, output occurrences,
                    output overflow, output last_result, input ready);
    modport sink   (input valid, input kind, input gram, input occurrences,
                    input overflow, input last_result, output ready);
endinterface

interface kfc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [kfc_pkg::LEN_W-1:0]   gram_length;

    modport source (output valid, output gram_length, input ready);
    modport sink   (input valid, input gram_length, output ready);
endinterface

// ----- hw/rtl/kgram_frequency_counter.sv -----
// Per text byte: when a gram completes, the table is read one entry per cycle
// and each entry compared with the window until a match or the table's end.
// Report after the last byte: a scan finds the largest count; if it is two or
// more, each gram with that count is sent, else one no-repeat result is sent.
// Synchronous active-low reset clears control state and sets gram_length to 1;
// the gram table is not cleared, entries beyond the fill count are never read.
module kgram_frequency_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfc_cfg_if.sink     i_cfg,
    kfc_in_if.sink      i_text,
    kfc_out_if.source   o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MAX,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_NOREP
    } t_state;

    t_state                          r_state;
    logic [kfc_pkg::LEN_W-1:0]       r_glen;
    logic [kfc_pkg::GRAM_W-1:0]      r_window;
    logic [kfc_pkg::TEXT_W-1:0]      r_bytes;
    logic [kfc_pkg::USED_W-1:0]      r_used;
    logic                            r_ovf;
    logic                            r_last;
    logic [kfc_pkg::GRAM_W-1:0]      r_gram;
    logic [kfc_pkg::USED_W-1:0]      r_ridx;
    logic [kfc_pkg::ADDR_W-1:0]      r_didx;
    logic                            r_dvld;
    logic [kfc_pkg::COUNT_W-1:0]     r_best;
    logic [kfc_pkg::ADDR_W-1:0]      r_lastidx;

    logic                            r_ovalid;
    logic                            r_okind;
    logic [kfc_pkg::GRAM_W-1:0]      r_ogram;
    logic [kfc_pkg::COUNT_W-1:0]     r_oocc;
    logic                            r_oovf;
    logic                            r_olast;

    kfc_pkg::t_entry                 mem [kfc_pkg::MAX_DISTINCT];
    kfc_pkg::t_entry                 r_rdata;

    logic                            rd_en;
    logic [kfc_pkg::ADDR_W-1:0]      rd_addr;
    logic                            wr_en;
    logic [kfc_pkg::ADDR_W-1:0]      wr_addr;
    kfc_pkg::t_entry                 wr_data;

    logic [kfc_pkg::LEN_W-1:0]       eff_n;
    logic [kfc_pkg::GRAM_W-1:0]      n_window;
    logic [kfc_pkg::TEXT_W-1:0]      n_bytes;
    logic                            in_fire;
    logic                            hit;
    logic                            more;
    logic                            out_free;
    logic                            emit;

    assign eff_n    = kfc_pkg::eff_length(r_glen);
    assign n_window = {r_window[kfc_pkg::GRAM_W-kfc_pkg::BYTE_W-1:0], i_text.text_byte};
    assign n_bytes  = r_bytes + kfc_pkg::TEXT_W'(1);
    assign in_fire  = i_text.valid && i_text.ready;
    assign hit      = r_dvld && (r_rdata.gram == r_gram);
    assign more     = r_ridx < r_used;
    assign out_free = !r_ovalid || o_result.ready;
    assign emit     = out_free && (((r_state == S_EMIT_CHK) && (r_rdata.count == r_best)) ||
                                   (r_state == S_NOREP));

    assign i_cfg.ready  = 1'b1;
    assign i_text.ready = (r_state == S_IDLE);

    assign o_result.valid       = r_ovalid;
    assign o_result.kind        = r_okind;
    assign o_result.gram        = r_ogram;
    assign o_result.occurrences = r_oocc;
    assign o_result.overflow    = r_oovf;
    assign o_result.last_result = r_olast;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ridx[kfc_pkg::ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_didx;
        wr_data = '{gram: r_gram, count: kfc_pkg::sat_inc(r_rdata.count)};
        unique case (r_state)
            S_SEARCH: begin
                if (hit) begin
                    wr_en = 1'b1;
                end else if (more) begin
                    rd_en = 1'b1;
                end else if (!r_dvld && (r_used < kfc_pkg::USED_W'(kfc_pkg::MAX_DISTINCT))) begin
                    wr_en   = 1'b1;
                    wr_addr = r_used[kfc_pkg::ADDR_W-1:0];
                    wr_data = '{gram: r_gram, count: kfc_pkg::COUNT_W'(1)};
                end
            end
            S_MAX: begin
                rd_en = more;
            end
            S_EMIT_RD: begin
                rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_glen    <= kfc_pkg::LEN_W'(1);
            r_window  <= '0;
            r_bytes   <= '0;
            r_used    <= '0;
            r_ovf     <= 1'b0;
            r_last    <= 1'b0;
            r_ridx    <= '0;
            r_didx    <= '0;
            r_dvld    <= 1'b0;
            r_best    <= '0;
            r_lastidx <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_glen <= i_cfg.gram_length;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_last <= i_text.is_last;
                        r_ridx <= '0;
                        r_dvld <= 1'b0;
                        r_best <= '0;
                        if (r_bytes < kfc_pkg::TEXT_W'(kfc_pkg::MAX_TEXT)) begin
                            r_window <= n_window;
                            r_bytes  <= n_bytes;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if ((r_bytes < kfc_pkg::TEXT_W'(kfc_pkg::MAX_TEXT)) &&
                            (n_bytes >= kfc_pkg::TEXT_W'(eff_n))) begin
                            r_gram  <= n_window & kfc_pkg::gram_mask(eff_n);
                            r_state <= S_SEARCH;
                        end else if (i_text.is_last) begin
                            r_state <= S_MAX;
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit || (!more && !r_dvld)) begin
                        if (!hit) begin
                            if (r_used < kfc_pkg::USED_W'(kfc_pkg::MAX_DISTINCT)) begin
                                r_used <= r_used + kfc_pkg::USED_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        r_ridx  <= '0;
                        r_dvld  <= 1'b0;
                        r_state <= r_last ? S_MAX : S_IDLE;
                    end else if (more) begin
                        r_didx <= r_ridx[kfc_pkg::ADDR_W-1:0];
                        r_dvld <= 1'b1;
                        r_ridx <= r_ridx + kfc_pkg::USED_W'(1);
                    end else begin
                        r_dvld <= 1'b0;
                    end
                end
                S_MAX: begin
                    if (r_dvld) begin
                        if (r_rdata.count > r_best) begin
                            r_best    <= r_rdata.count;
                            r_lastidx <= r_didx;
                        end else if (r_rdata.count == r_best) begin
                            r_lastidx <= r_didx;
                        end
                    end
                    if (more) begin
                        r_didx <= r_ridx[kfc_pkg::ADDR_W-1:0];
                        r_dvld <= 1'b1;
                        r_ridx <= r_ridx + kfc_pkg::USED_W'(1);
                    end else begin
                        r_dvld <= 1'b0;
                        if (!r_dvld) begin
                            r_ridx  <= '0;
                            r_state <= (r_best >= kfc_pkg::COUNT_W'(2)) ? S_EMIT_RD : S_NOREP;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_didx  <= r_ridx[kfc_pkg::ADDR_W-1:0];
                    r_ridx  <= r_ridx + kfc_pkg::USED_W'(1);
                    r_state <= S_EMIT_CHK;
                end
                S_EMIT_CHK: begin
                    if (r_rdata.count != r_best) begin
                        r_state <= S_EMIT_RD;
                    end else if (out_free) begin
                        r_okind  <= kfc_pkg::KIND_FREQUENT;
                        r_ogram  <= r_rdata.gram;
                        r_oocc   <= r_best;
                        r_oovf   <= r_ovf;
                        r_olast  <= (r_didx == r_lastidx);
                        if (r_didx == r_lastidx) begin
                            r_window <= '0;
                            r_bytes  <= '0;
                            r_used   <= '0;
                            r_ovf    <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_NOREP: begin
                    if (out_free) begin
                        r_okind  <= kfc_pkg::KIND_NO_REPEAT;
                        r_ogram  <= '0;
                        r_oocc   <= r_best;
                        r_oovf   <= r_ovf;
                        r_olast  <= 1'b1;
                        r_window <= '0;
                        r_bytes  <= '0;
                        r_used   <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= kfc_pkg::USED_W'(kfc_pkg::MAX_DISTINCT))
        else $error("gram table fill count beyond capacity");

    a_text_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= kfc_pkg::TEXT_W'(kfc_pkg::MAX_TEXT))
        else $error("text byte count beyond capacity");

    a_norep_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == kfc_pkg::KIND_NO_REPEAT)) |->
            (r_oocc < kfc_pkg::COUNT_W'(2)) && (r_ogram == '0) && r_olast)
        else $error("no-repeat result with a repeated count");

    a_freq_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == kfc_pkg::KIND_FREQUENT)) |->
            (r_oocc >= kfc_pkg::COUNT_W'(2)))
        else $error("frequent gram result with a count below two");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS_PER_PHASE = 100;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        kfc_pkg::t_kind              kind;
        logic [kfc_pkg::GRAM_W-1:0]  gram;
        logic [kfc_pkg::COUNT_W-1:0] occurrences;
        logic                        overflow;
        logic                        last_result;
    } t_gram_report;

    typedef t_gram_report t_report_q[$];

    typedef enum {
        ROW_TEXT,
        ROW_CFG
    } t_stim_op;

    typedef struct {
        t_stim_op     op;
        logic [7:0]   value;
        logic         last;
        bit           typed;
        t_gram_report report;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    kfc_cfg_if cfg_bus ();
    kfc_in_if  text_bus ();
    kfc_out_if result_bus ();

    kgram_frequency_counter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_text   (text_bus),
        .o_result (result_bus)
    );

    logic [kfc_pkg::GRAM_W-1:0]  gram_table [kfc_pkg::MAX_DISTINCT];
    logic [kfc_pkg::COUNT_W-1:0] gram_hits  [kfc_pkg::MAX_DISTINCT];
    logic [kfc_pkg::GRAM_W-1:0]  window_bytes;
    int                          text_len;
    int                          table_fill;
    logic                        dropped_flag;
    logic [kfc_pkg::LEN_W-1:0]   gram_len_reg;

    t_gram_report expected_reports[$];
    t_stim_row    directed_rows[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int phase_items;

    always #1 i_clk = ~i_clk;

    function automatic logic [kfc_pkg::GRAM_W-1:0] window_mask(input int n);
        if (n >= kfc_pkg::MAX_GRAM) begin
            return '1;
        end
        return (kfc_pkg::GRAM_W'(1) << (n * 8)) - kfc_pkg::GRAM_W'(1);
    endfunction

    // Each accepted request is folded into the predicted gram table.
    function automatic void count_text_byte(input logic [7:0] b, input logic last,
                                            inout t_report_q fresh);
        int                         n;
        int                         best;
        int                         hits;
        int                         emitted;
        bit                         found;
        logic [kfc_pkg::GRAM_W-1:0] g;
        t_gram_report               r;
        n = int'(gram_len_reg);
        if (n < 1) begin
            n = 1;
        end
        if (n > kfc_pkg::MAX_GRAM) begin
            n = kfc_pkg::MAX_GRAM;
        end
        if (text_len < kfc_pkg::MAX_TEXT) begin
            window_bytes = {window_bytes[kfc_pkg::GRAM_W-9:0], b};
            text_len++;
            if (text_len >= n) begin
                g = window_bytes & window_mask(n);
                found = 1'b0;
                for (int i = 0; i < table_fill; i++) begin
                    if (!found && gram_table[i] == g) begin
                        found = 1'b1;
                        if (gram_hits[i] != kfc_pkg::COUNT_MAX) begin
                            gram_hits[i] = gram_hits[i] + kfc_pkg::COUNT_W'(1);
                        end
                    end
                end
                if (!found) begin
                    if (table_fill < kfc_pkg::MAX_DISTINCT) begin
                        gram_table[table_fill] = g;
                        gram_hits[table_fill] = kfc_pkg::COUNT_W'(1);
                        table_fill++;
                    end else begin
                        dropped_flag = 1'b1;
                    end
                end
            end
        end else begin
            dropped_flag = 1'b1;
        end
        if (!last) begin
            return;
        end
        best = 0;
        hits = 0;
        for (int i = 0; i < table_fill; i++) begin
            if (int'(gram_hits[i]) > best) begin
                best = int'(gram_hits[i]);
            end
        end
        if (best >= 2) begin
            for (int i = 0; i < table_fill; i++) begin
                if (int'(gram_hits[i]) == best) begin
                    hits++;
                end
            end
            emitted = 0;
            for (int i = 0; i < table_fill; i++) begin
                if (int'(gram_hits[i]) == best) begin
                    emitted++;
                    r.kind = kfc_pkg::KIND_FREQUENT;
                    r.gram = gram_table[i];
                    r.occurrences = kfc_pkg::COUNT_W'(best);
                    r.overflow = dropped_flag;
                    r.last_result = (emitted == hits);
                    fresh.push_back(r);
                end
            end
        end else begin
            r.kind = kfc_pkg::KIND_NO_REPEAT;
            r.gram = '0;
            r.occurrences = kfc_pkg::COUNT_W'(best);
            r.overflow = dropped_flag;
            r.last_result = 1'b1;
            fresh.push_back(r);
        end
        window_bytes = '0;
        text_len = 0;
        table_fill = 0;
        dropped_flag = 1'b0;
    endfunction

    function automatic t_stim_row text_row(input logic [7:0] b, input logic last);
        t_stim_row row;
        row.op = ROW_TEXT;
        row.value = b;
        row.last = last;
        row.typed = 1'b0;
        row.report.kind = kfc_pkg::KIND_FREQUENT;
        row.report.gram = '0;
        row.report.occurrences = '0;
        row.report.overflow = 1'b0;
        row.report.last_result = 1'b0;
        return row;
    endfunction

    function automatic t_stim_row typed_row(input logic [7:0] b,
                                            input kfc_pkg::t_kind kind,
                                            input logic [kfc_pkg::GRAM_W-1:0] g,
                                            input logic [kfc_pkg::COUNT_W-1:0] occ);
        t_stim_row row;
        row = text_row(b, 1'b1);
        row.typed = 1'b1;
        row.report.kind = kind;
        row.report.gram = g;
        row.report.occurrences = occ;
        row.report.last_result = 1'b1;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [kfc_pkg::LEN_W-1:0] v);
        t_stim_row row;
        row = text_row(8'(v), 1'b0);
        row.op = ROW_CFG;
        return row;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input t_gram_report typed_report);
        t_report_q fresh;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            text_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        text_bus.valid <= 1'b1;
        text_bus.text_byte <= b;
        text_bus.is_last <= last;
        do @(posedge i_clk); while (!text_bus.ready);
        fresh = {};
        count_text_byte(b, last, fresh);
        if (typed) begin
            expected_reports.push_back(typed_report);
        end else begin
            foreach (fresh[i]) begin
                expected_reports.push_back(fresh[i]);
            end
        end
    endtask

    task automatic drain_reports();
        text_bus.valid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic settle();
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gram_length(input logic [kfc_pkg::LEN_W-1:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.gram_length <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        gram_len_reg = v;
    endtask

    task automatic send_plain(input logic [7:0] b, input logic last);
        t_stim_row row;
        row = text_row(b, last);
        send_byte(b, last, 1'b0, row.report);
    endtask

    task automatic run_random_text();
        int         text_bytes;
        int         alpha_n;
        bit         noisy;
        logic [7:0] alphabet [4];
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            settle();
            write_gram_length(kfc_pkg::LEN_W'($urandom_range(0, 7)));
        end
        text_bytes = $urandom_range(1, 16);
        noisy = ($urandom_range(0, 7) == 0);
        alpha_n = $urandom_range(1, 4);
        for (int a = 0; a < 4; a++) begin
            alphabet[a] = 8'($urandom_range(0, 255));
        end
        for (int k = 0; k < text_bytes; k++) begin
            if (k > 0 && $urandom_range(0, 39) == 0) begin
                drain_reports();
            end
            if (noisy) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = alphabet[$urandom_range(0, alpha_n - 1)];
            end
            send_plain(b, k == text_bytes - 1);
            phase_items++;
        end
    endtask

    task automatic run_long_text();
        logic [7:0] pair [2];
        settle();
        write_gram_length(kfc_pkg::LEN_W'($urandom_range(1, 4)));
        pair[0] = 8'($urandom_range(0, 255));
        pair[1] = 8'($urandom_range(0, 255));
        for (int k = 0; k < kfc_pkg::MAX_TEXT + 8; k++) begin
            send_plain(pair[$urandom_range(0, 1)], k == kfc_pkg::MAX_TEXT + 7);
        end
    endtask

    task automatic run_full_table_text();
        settle();
        write_gram_length(kfc_pkg::LEN_W'(1));
        for (int k = 0; k < kfc_pkg::MAX_DISTINCT; k++) begin
            send_plain(8'(k), 1'b0);
        end
        for (int k = 0; k < kfc_pkg::MAX_DISTINCT; k++) begin
            send_plain(8'((k * 37) % kfc_pkg::MAX_DISTINCT), 1'b0);
        end
        for (int k = 0; k < 8; k++) begin
            send_plain(8'($urandom_range(kfc_pkg::MAX_DISTINCT, 255)), k == 7);
        end
    endtask

    task automatic note_mismatch();
        mismatch_count++;
    endtask

    task automatic check_result();
        t_gram_report want;
        if (expected_reports.size() == 0) begin
            note_mismatch();
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("unexpected result: kind %0d gram %h occ %0d ovf %0d last %0d",
                         result_bus.kind, result_bus.gram, result_bus.occurrences,
                         result_bus.overflow, result_bus.last_result);
            end
        end else begin
            want = expected_reports.pop_front();
            if (result_bus.kind !== want.kind || result_bus.gram !== want.gram ||
                result_bus.occurrences !== want.occurrences ||
                result_bus.overflow !== want.overflow ||
                result_bus.last_result !== want.last_result) begin
                note_mismatch();
                if (mismatch_count <= REPORT_LIMIT) begin
                $display("exp/act kind %0d/%0d gram %h/%h occ %0d/%0d ovf %0d/%0d last %0d/%0d",
                         want.kind, result_bus.kind, want.gram, result_bus.gram,
                         want.occurrences, result_bus.occurrences,
                         want.overflow, result_bus.overflow,
                         want.last_result, result_bus.last_result);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            check_result();
        end
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.gram_length = '0;
        text_bus.valid = 1'b0;
        text_bus.text_byte = '0;
        text_bus.is_last = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        phase_items = 0;
        window_bytes = '0;
        text_len = 0;
        table_fill = 0;
        dropped_flag = 1'b0;
        gram_len_reg = kfc_pkg::LEN_W'(1);

        directed_rows.push_back(typed_row(8'h00, kfc_pkg::KIND_NO_REPEAT, 32'h0, 10'd1));
        directed_rows.push_back(text_row(8'hFF, 1'b0));
        directed_rows.push_back(typed_row(8'hFF, kfc_pkg::KIND_FREQUENT, 32'h0000_00FF,
                                          10'd2));
        directed_rows.push_back(text_row(8'h41, 1'b0));
        directed_rows.push_back(text_row(8'h42, 1'b0));
        directed_rows.push_back(text_row(8'h41, 1'b0));
        directed_rows.push_back(text_row(8'h42, 1'b1));
        directed_rows.push_back(cfg_row(kfc_pkg::LEN_W'(4)));
        directed_rows.push_back(text_row(8'h01, 1'b0));
        directed_rows.push_back(text_row(8'h02, 1'b0));
        directed_rows.push_back(typed_row(8'h03, kfc_pkg::KIND_NO_REPEAT, 32'h0, 10'd0));
        directed_rows.push_back(text_row(8'hDE, 1'b0));
        directed_rows.push_back(text_row(8'hAD, 1'b0));
        directed_rows.push_back(text_row(8'hBE, 1'b0));
        directed_rows.push_back(text_row(8'hEF, 1'b0));
        directed_rows.push_back(text_row(8'hDE, 1'b0));
        directed_rows.push_back(text_row(8'hAD, 1'b0));
        directed_rows.push_back(text_row(8'hBE, 1'b0));
        directed_rows.push_back(typed_row(8'hEF, kfc_pkg::KIND_FREQUENT, 32'hDEAD_BEEF,
                                          10'd2));
        directed_rows.push_back(cfg_row(kfc_pkg::LEN_W'(0)));
        directed_rows.push_back(text_row(8'h07, 1'b0));
        directed_rows.push_back(typed_row(8'h07, kfc_pkg::KIND_FREQUENT, 32'h0000_0007,
                                          10'd2));
        directed_rows.push_back(cfg_row(kfc_pkg::LEN_W'(7)));
        directed_rows.push_back(text_row(8'h00, 1'b0));
        directed_rows.push_back(text_row(8'h00, 1'b0));
        directed_rows.push_back(text_row(8'h00, 1'b0));
        directed_rows.push_back(typed_row(8'h00, kfc_pkg::KIND_NO_REPEAT, 32'h0, 10'd1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                settle();
                write_gram_length(directed_rows[i].value[kfc_pkg::LEN_W-1:0]);
            end else begin
                send_byte(directed_rows[i].value, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].report);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 60;
                end
                default: begin
                    send_idle_pct = 7;
                    recv_stall_pct = 7;
                end
            endcase
            settle();
            if (phase == 0) begin
                run_long_text();
            end
            if (phase == 2) begin
                run_full_table_text();
            end
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS_PER_PHASE) begin
                run_random_text();
            end
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
